### hw/rtl/assert_macros.svh
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AGA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define AGA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AGA_ASSERT(lbl, clk, rst_n, prop)
`define AGA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/aga_pkg.sv
// Types, constants and helpers for the atlas allocator
package aga_pkg;

  localparam int MAX_PAGES   = 8;
  localparam int PAGE_W      = $clog2(MAX_PAGES);
  localparam int MAX_REGIONS = 64;
  localparam int REG_AW      = $clog2(MAX_REGIONS);
  localparam int LEN_W       = $clog2(MAX_REGIONS + 1);
  localparam int MAX_EDGE    = 8190;
  localparam int CLASS_COUNT = 4;
  localparam int PAD         = 2;
  localparam int EXTENT_CAP  = 8192;
  localparam logic [13:0] MIN_EXT_RESET = 14'd1024;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RK_ERR   = 2'd0,
    RK_REL   = 2'd1,
    RK_ALLOC = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [12:0]       x;
    logic [12:0]       y;
    logic [13:0]       w;
    logic [13:0]       h;
  } region_t;

  typedef struct packed {
    logic      load_req;
    logic      init;
    logic      run;
    logic      filt;
    logic      len_from_wr;
    logic      rel_update;
    logic      push_rel;
    logic      new_page;
    logic      push_right;
    logic      push_bottom;
    logic      res_load;
    res_kind_t res_kind;
    status_t   res_status;
    logic      res_drop;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic bad;
    logic ext_bad;
    logic rel_valid;
    logic rel_zero;
    logic len_full;
    logic scan_done;
    logic found;
    logic rem_fail;
    logic no_slot;
    logic net_fail;
    logic out_free;
  } sts_t;

  function automatic logic [14:0] next_pow2(input logic [13:0] m);
    logic [13:0] v;
    logic [14:0] c;
    v = m - 14'd1;
    c = 15'd1;
    for (int i = 0; i < 14; i++) begin
      if (v[i]) c = 15'(15'd1 << (i + 1));
    end
    return c;
  endfunction

  function automatic logic [PAGE_W-1:0] first_free(input logic [MAX_PAGES-1:0] v);
    logic [PAGE_W-1:0] s;
    s = '0;
    for (int i = MAX_PAGES - 1; i >= 0; i--) begin
      if (!v[i]) s = PAGE_W'(i);
    end
    return s;
  endfunction

endpackage

### hw/rtl/aga_ctrl.sv
// Sequencer for allocate and release requests
module aga_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  aga_pkg::sts_t sts,
  output aga_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_FILTER = 8'b0001_0000,
    S_PUSH_R = 8'b0010_0000,
    S_PUSH_B = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.res_kind   = aga_pkg::RK_ERR;
    cmd.res_status = aga_pkg::ST_OK;
    state_nxt  = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.mode) begin
          if (sts.bad) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = aga_pkg::ST_BAD;
            state_nxt      = S_FINISH;
          end else begin
            cmd.init  = 1'b1;
            state_nxt = S_SCAN;
          end
        end else if (!sts.rel_valid) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = aga_pkg::RK_REL;
          state_nxt    = S_FINISH;
        end else begin
          cmd.rel_update = 1'b1;
          if (sts.rel_zero) begin
            cmd.init     = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_kind = aga_pkg::RK_REL;
            cmd.res_drop = 1'b1;
            state_nxt    = S_FILTER;
          end else if (sts.len_full) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = aga_pkg::ST_FULL;
            state_nxt      = S_FINISH;
          end else begin
            cmd.push_rel = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_kind = aga_pkg::RK_REL;
            state_nxt    = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        cmd.run = 1'b1;
        if (sts.scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.found) begin
          if (sts.rem_fail) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = aga_pkg::ST_FULL;
            state_nxt      = S_FINISH;
          end else begin
            cmd.init  = 1'b1;
            state_nxt = S_FILTER;
          end
        end else if (sts.ext_bad) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = aga_pkg::ST_BAD;
          state_nxt      = S_FINISH;
        end else if (sts.no_slot) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = aga_pkg::ST_NO_SLOT;
          state_nxt      = S_FINISH;
        end else if (sts.net_fail) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = aga_pkg::ST_FULL;
          state_nxt      = S_FINISH;
        end else begin
          cmd.new_page = 1'b1;
          state_nxt    = S_PUSH_R;
        end
      end
      S_FILTER: begin
        cmd.run  = 1'b1;
        cmd.filt = 1'b1;
        if (sts.scan_done) begin
          cmd.len_from_wr = 1'b1;
          state_nxt       = sts.mode ? S_FINISH : S_PUSH_R;
        end
      end
      S_PUSH_R: begin
        cmd.push_right = 1'b1;
        state_nxt      = S_PUSH_B;
      end
      S_PUSH_B: begin
        cmd.push_bottom = 1'b1;
        cmd.res_load    = 1'b1;
        cmd.res_kind    = aga_pkg::RK_ALLOC;
        state_nxt       = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

### hw/rtl/aga_dp.sv
// Page table, free-rectangle memory, search and compaction datapath
module aga_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  aga_pkg::cmd_t cmd,
  output aga_pkg::sts_t sts,
  input  logic          cfg_we,
  input  logic [13:0]   cfg_wdata,
  input  logic          in_mode,
  input  logic [1:0]    in_storage_class,
  input  logic [2:0]    in_page_index,
  input  logic [12:0]   in_pos_x,
  input  logic [12:0]   in_pos_y,
  input  logic [13:0]   in_size_w,
  input  logic [13:0]   in_size_h,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_status,
  output logic [2:0]    out_page,
  output logic [12:0]   out_x,
  output logic [12:0]   out_y,
  output logic [13:0]   out_extent,
  output logic          out_page_dropped
);

  localparam int NP = aga_pkg::MAX_PAGES;
  localparam int PW = aga_pkg::PAGE_W;
  localparam int AW = aga_pkg::REG_AW;
  localparam int LW = aga_pkg::LEN_W;

  logic [13:0] min_ext_r;

  logic        mode_r;
  logic [1:0]  cls_r;
  logic [2:0]  pg_r;
  logic [12:0] x_r, y_r;
  logic [13:0] w_r, h_r;

  logic [NP-1:0] pv_r;
  logic [1:0]    pcls_r [NP];
  logic [13:0]   pside_r[NP];
  logic [15:0]   pcnt_r [NP];
  logic [15:0]   pord_r [NP];
  logic [15:0]   ctr_r;
  logic [LW-1:0] len_r;

  aga_pkg::region_t mem [aga_pkg::MAX_REGIONS];
  aga_pkg::region_t rdata_r, mem_wd;
  logic [AW-1:0]    mem_wa;
  logic             mem_we;

  logic [LW-1:0] cnt_r, wr_r;
  logic          sv_r;
  logic [AW-1:0] sidx_r;

  logic             found_r;
  aga_pkg::region_t best_r;
  logic [AW-1:0]    best_idx_r;
  logic [15:0]      best_age_r;

  logic [13:0] ext_r, ext_c, pw, ph, mx;
  logic [14:0] c2, cmax;

  logic [1:0]  res_status_r;
  logic [2:0]  res_page_r;
  logic [12:0] res_x_r, res_y_r;
  logic [13:0] res_ext_r;
  logic        res_drop_r;
  logic        out_valid_r;

  logic [15:0] age;
  logic        fit, better, drop, need_r, need_b;
  logic [1:0]  rem, net;
  logic [15:0] cnt_dec;
  logic [PW-1:0] slot;

  assign pw = w_r + 14'(aga_pkg::PAD);
  assign ph = h_r + 14'(aga_pkg::PAD);
  assign mx = (pw > ph) ? pw : ph;
  assign c2 = aga_pkg::next_pow2(mx);
  assign cmax = ({1'b0, min_ext_r} > c2) ? {1'b0, min_ext_r} : c2;
  assign ext_c = (int'(cmax) > aga_pkg::EXTENT_CAP) ? 14'(aga_pkg::EXTENT_CAP)
                                                     : cmax[13:0];

  assign age    = ctr_r - pord_r[rdata_r.page];
  assign fit    = pv_r[rdata_r.page] && (pcls_r[rdata_r.page] == cls_r) &&
                  (rdata_r.w >= pw) && (rdata_r.h >= ph);
  assign better = !found_r || (age > best_age_r) ||
                  ((age == best_age_r) && (rdata_r.page < best_r.page));
  assign drop   = mode_r ? (rdata_r.page == pg_r) : (sidx_r == best_idx_r);
  assign need_r = best_r.w > pw;
  assign need_b = best_r.h > ph;
  assign rem    = {1'b0, need_r} + {1'b0, need_b};
  assign net    = {1'b0, ext_r > pw} + {1'b0, ext_r > ph};
  assign cnt_dec = (pcnt_r[pg_r] != 16'd0) ? pcnt_r[pg_r] - 16'd1 : pcnt_r[pg_r];
  assign slot   = aga_pkg::first_free(pv_r);

  always_comb begin
    sts.mode      = mode_r;
    sts.bad       = (w_r == 14'd0) || (h_r == 14'd0) ||
                    (int'(w_r) > aga_pkg::MAX_EDGE) || (int'(h_r) > aga_pkg::MAX_EDGE) ||
                    (int'(cls_r) >= aga_pkg::CLASS_COUNT);
    sts.ext_bad   = (pw > ext_r) || (ph > ext_r);
    sts.rel_valid = pv_r[pg_r];
    sts.rel_zero  = (cnt_dec == 16'd0);
    sts.len_full  = int'(len_r) >= aga_pkg::MAX_REGIONS;
    sts.scan_done = (cnt_r >= len_r) && !sv_r;
    sts.found     = found_r;
    sts.rem_fail  = (int'(len_r) + int'(rem) - 1) > aga_pkg::MAX_REGIONS;
    sts.no_slot   = &pv_r;
    sts.net_fail  = (int'(len_r) + int'(net)) > aga_pkg::MAX_REGIONS;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = len_r[AW-1:0];
    mem_wd = best_r;
    if (cmd.run && cmd.filt && sv_r && !drop) begin
      mem_we = 1'b1;
      mem_wa = wr_r[AW-1:0];
      mem_wd = rdata_r;
    end else if (cmd.push_rel) begin
      mem_we = 1'b1;
      mem_wd = '{page: pg_r, x: x_r, y: y_r, w: w_r, h: h_r};
    end else if (cmd.push_right) begin
      mem_we = need_r;
      mem_wd = '{page: best_r.page, x: best_r.x + pw[12:0], y: best_r.y,
                 w: best_r.w - pw, h: ph};
    end else if (cmd.push_bottom) begin
      mem_we = need_b;
      mem_wd = '{page: best_r.page, x: best_r.x, y: best_r.y + ph[12:0],
                 w: best_r.w, h: best_r.h - ph};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[cnt_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ext_r   <= aga_pkg::MIN_EXT_RESET;
      pv_r        <= '0;
      ctr_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      sv_r        <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      if (cfg_we) min_ext_r <= cfg_wdata;

      if (cmd.init) begin
        cnt_r   <= '0;
        sv_r    <= 1'b0;
        found_r <= 1'b0;
      end else if (cmd.run) begin
        sv_r <= cnt_r < len_r;
        if (cnt_r < len_r) cnt_r <= cnt_r + LW'(1);
        if (!cmd.filt && sv_r && fit && better) found_r <= 1'b1;
      end

      if (cmd.rel_update) begin
        pcnt_r[pg_r] <= cnt_dec;
        if (cnt_dec == 16'd0) pv_r[pg_r] <= 1'b0;
      end
      if (cmd.new_page) begin
        pv_r[slot]    <= 1'b1;
        pcls_r[slot]  <= cls_r;
        pside_r[slot] <= ext_r;
        pcnt_r[slot]  <= '0;
        pord_r[slot]  <= ctr_r;
        ctr_r         <= ctr_r + 16'd1;
      end
      if (cmd.push_bottom && pcnt_r[best_r.page] != 16'hFFFF)
        pcnt_r[best_r.page] <= pcnt_r[best_r.page] + 16'd1;

      if (cmd.len_from_wr) len_r <= wr_r;
      else if (mem_we && !cmd.filt) len_r <= len_r + LW'(1);

      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ext_r <= ext_c;
    if (cmd.load_req) begin
      mode_r <= in_mode;
      cls_r  <= in_storage_class;
      pg_r   <= in_page_index;
      x_r    <= in_pos_x;
      y_r    <= in_pos_y;
      w_r    <= in_size_w;
      h_r    <= in_size_h;
    end
    if (cmd.init) begin
      wr_r <= '0;
    end else if (cmd.run) begin
      sidx_r <= cnt_r[AW-1:0];
      if (cmd.filt && sv_r && !drop) wr_r <= wr_r + LW'(1);
      if (!cmd.filt && sv_r && fit && better) begin
        best_r     <= rdata_r;
        best_idx_r <= sidx_r;
        best_age_r <= age;
      end
    end
    if (cmd.new_page) best_r <= '{page: slot, x: '0, y: '0, w: ext_r, h: ext_r};
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_page_r   <= '0;
      res_x_r      <= '0;
      res_y_r      <= '0;
      res_ext_r    <= '0;
      res_drop_r   <= 1'b0;
      case (cmd.res_kind)
        aga_pkg::RK_REL: begin
          res_page_r <= pg_r;
          res_drop_r <= cmd.res_drop;
        end
        aga_pkg::RK_ALLOC: begin
          res_page_r <= best_r.page;
          res_x_r    <= best_r.x;
          res_y_r    <= best_r.y;
          res_ext_r  <= pside_r[best_r.page];
        end
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_status       <= res_status_r;
      out_page         <= res_page_r;
      out_x            <= res_x_r;
      out_y            <= res_y_r;
      out_extent       <= res_ext_r;
      out_page_dropped <= res_drop_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hw/rtl/atlas_guillotine_allocator_unit.sv
// Top level of the guillotine texture-atlas allocator
//
// Input channel (in_valid / in_stall) carries one request word: allocate
// (in_mode 0) or release (in_mode 1). Result channel (out_valid / out_stall)
// returns exactly one result word per request. cfg_we / cfg_wdata set the
// minimum page side; write it only while no request is in flight.
// One request is processed at a time; in_stall is high from acceptance until
// the result has been placed in the output register.
// Each pass walks the free-rectangle list (up to 64 entries). Allocate into
// an existing rectangle: a search pass that picks the first fitting rectangle
// on the oldest page of the class, then a second pass to compact it out;
// allocate on a new page, or refused after the search: the search pass only.
// Release: no pass, or one pass when the page empties and its rectangles are
// compacted out. Bad sizes: no pass.
// The result waits in the output register while out_stall is high; the next
// request may still be accepted, and its own result waits behind it.
// Reset (rst_n low, synchronous) empties the page table and rectangle list
// and restores the minimum page side to 1024; no clearing pass is needed.
`include "assert_macros.svh"

module atlas_guillotine_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [13:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [1:0]  in_storage_class,
  input  logic [2:0]  in_page_index,
  input  logic [12:0] in_pos_x,
  input  logic [12:0] in_pos_y,
  input  logic [13:0] in_size_w,
  input  logic [13:0] in_size_h,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_page,
  output logic [12:0] out_x,
  output logic [12:0] out_y,
  output logic [13:0] out_extent,
  output logic        out_page_dropped
);

  aga_pkg::cmd_t cmd;
  aga_pkg::sts_t sts;

  aga_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  aga_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_mode          (in_mode),
    .in_storage_class (in_storage_class),
    .in_page_index    (in_page_index),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_size_w        (in_size_w),
    .in_size_h        (in_size_h),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_page         (out_page),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_extent       (out_extent),
    .out_page_dropped (out_page_dropped)
  );

  `AGA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `AGA_ASSERT(a_slot_held, clk, rst_n, !sts.out_free |-> out_valid)
  `AGA_ASSERT(a_result_from_busy, clk, rst_n, $rose(out_valid) |-> $past(in_stall))

endmodule

### tb/atlas_guillotine_allocator_checker.sv
// Checker for the atlas allocator: mirrors page and free-rectangle state, compares each result word
`timescale 1ns / 1ps

module atlas_guillotine_allocator_checker
  import aga_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [13:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_mode,
  input  logic [1:0]  in_storage_class,
  input  logic [2:0]  in_page_index,
  input  logic [12:0] in_pos_x,
  input  logic [12:0] in_pos_y,
  input  logic [13:0] in_size_w,
  input  logic [13:0] in_size_h,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [2:0]  out_page,
  input  logic [12:0] out_x,
  input  logic [12:0] out_y,
  input  logic [13:0] out_extent,
  input  logic        out_page_dropped,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    status_t     status;
    logic [2:0]  page;
    logic [12:0] x;
    logic [12:0] y;
    logic [13:0] extent;
    logic        dropped;
  } alloc_result_t;

  localparam logic MODE_ALLOC = 1'b0;

  alloc_result_t result_q[$];
  logic [13:0]   min_side;
  logic          pg_live  [MAX_PAGES];
  logic [1:0]    pg_class [MAX_PAGES];
  logic [13:0]   pg_side  [MAX_PAGES];
  logic [15:0]   pg_uses  [MAX_PAGES];
  logic [15:0]   pg_born  [MAX_PAGES];
  logic [15:0]   born_ctr;
  region_t       free_list[$];

  function automatic alloc_result_t pack(status_t st, logic [2:0] pg, logic [12:0] x,
                                         logic [12:0] y, logic [13:0] e, logic d);
    alloc_result_t r;
    r.status = st; r.page = pg; r.x = x; r.y = y; r.extent = e; r.dropped = d;
    return r;
  endfunction

  function automatic void add_rect(int pg, int x, int y, int w, int h);
    region_t r;
    r.page = pg[2:0]; r.x = x[12:0]; r.y = y[12:0]; r.w = w[13:0]; r.h = h[13:0];
    free_list.insert(free_list.size(), r);
  endfunction

  function automatic alloc_result_t allocate(int cls, int sw, int sh);
    int pw, ph, best, found, page, rem, m, c, ext, net;
    logic [15:0] best_age, age;
    logic tried[MAX_PAGES];
    region_t r;
    found = -1; page = -1;
    if (sw == 0 || sh == 0 || sw > MAX_EDGE || sh > MAX_EDGE || cls >= CLASS_COUNT)
      return pack(ST_BAD, 0, 0, 0, 0, 0);
    pw = sw + PAD; ph = sh + PAD;
    foreach (tried[p]) tried[p] = 1'b0;
    forever begin
      best = -1; best_age = 0;
      for (int p = 0; p < MAX_PAGES; p++) begin
        if (!pg_live[p] || tried[p] || pg_class[p] != cls) continue;
        age = born_ctr - pg_born[p];
        if (best < 0 || age > best_age) begin
          best = p; best_age = age;
        end
      end
      if (best < 0) break;
      tried[best] = 1'b1;
      foreach (free_list[i]) begin
        if (free_list[i].page == best && free_list[i].w >= pw && free_list[i].h >= ph) begin
          found = i; page = best; break;
        end
      end
      if (found >= 0) break;
    end
    if (found >= 0) begin
      r = free_list[found];
      rem = (r.w > pw) + (r.h > ph);
      if (rem > 1 && free_list.size() + rem - 1 > MAX_REGIONS)
        return pack(ST_FULL, 0, 0, 0, 0, 0);
    end else begin
      m = pw > ph ? pw : ph; c = 1;
      while (c < m) c = c << 1;
      ext = min_side > c ? min_side : c;
      if (ext > EXTENT_CAP) ext = EXTENT_CAP;
      if (pw > ext || ph > ext) return pack(ST_BAD, 0, 0, 0, 0, 0);
      for (int p = 0; p < MAX_PAGES; p++)
        if (!pg_live[p]) begin
          page = p; break;
        end
      if (page < 0) return pack(ST_NO_SLOT, 0, 0, 0, 0, 0);
      net = (ext > pw) + (ext > ph);
      if (free_list.size() + net > MAX_REGIONS) return pack(ST_FULL, 0, 0, 0, 0, 0);
      pg_live[page] = 1'b1; pg_class[page] = cls[1:0]; pg_side[page] = ext[13:0];
      pg_uses[page] = 0; pg_born[page] = born_ctr; born_ctr = born_ctr + 1;
      add_rect(page, 0, 0, ext, ext);
      found = free_list.size() - 1;
    end
    r = free_list[found];
    free_list.delete(found);
    if (r.w > pw) add_rect(page, r.x + pw, r.y, r.w - pw, ph);
    if (r.h > ph) add_rect(page, r.x, r.y + ph, r.w, r.h - ph);
    if (pg_uses[page] != 16'hFFFF) pg_uses[page]++;
    return pack(ST_OK, page[2:0], r.x, r.y, pg_side[page], 0);
  endfunction

  function automatic alloc_result_t release_rect(int pg, int x, int y, int w, int h);
    int i;
    if (!pg_live[pg]) return pack(ST_OK, pg[2:0], 0, 0, 0, 0);
    if (pg_uses[pg] > 0) pg_uses[pg]--;
    if (pg_uses[pg] == 0) begin
      pg_live[pg] = 1'b0;
      i = 0;
      while (i < free_list.size()) begin
        if (free_list[i].page == pg) free_list.delete(i);
        else i++;
      end
      return pack(ST_OK, pg[2:0], 0, 0, 0, 1);
    end
    if (free_list.size() >= MAX_REGIONS) return pack(ST_FULL, 0, 0, 0, 0, 0);
    add_rect(pg, x, y, w, h);
    return pack(ST_OK, pg[2:0], 0, 0, 0, 0);
  endfunction

  always @(posedge clk) begin
    alloc_result_t got, want;
    if (!rst_n) begin
      min_side <= MIN_EXT_RESET;
      for (int p = 0; p < MAX_PAGES; p++) begin
        pg_live[p] = 1'b0; pg_class[p] = 0; pg_side[p] = 0; pg_uses[p] = 0; pg_born[p] = 0;
      end
      born_ctr = 0;
      free_list.delete();
      result_q.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (cfg_we) min_side <= cfg_wdata;
      if (in_valid && !in_stall) begin
        if (in_mode == MODE_ALLOC)
          result_q.insert(result_q.size(), allocate(in_storage_class, in_size_w, in_size_h));
        else
          result_q.insert(result_q.size(), release_rect(in_page_index, in_pos_x, in_pos_y,
                                                        in_size_w, in_size_h));
      end
      if (out_valid && !out_stall) begin
        got = pack(status_t'(out_status), out_page, out_x, out_y, out_extent,
                   out_page_dropped);
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", got);
        end else begin
          want = result_q.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: st %0d/%0d pg %0d/%0d x %0d/%0d y %0d/%0d ext %0d/%0d drop %0d/%0d",
                       want.status, got.status, want.page, got.page, want.x, got.x,
                       want.y, got.y, want.extent, got.extent, want.dropped, got.dropped);
          end
        end
      end
      pending = result_q.size();
    end
  end

endmodule

### tb/atlas_guillotine_allocator_unit_tb.sv
// Testbench top for the atlas allocator: stimulus, idling, and verdict
`timescale 1ns / 1ps

module atlas_guillotine_allocator_unit_tb;
  import aga_pkg::*;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef struct {
    logic [2:0]  page;
    logic [12:0] x;
    logic [12:0] y;
    logic [13:0] w;
    logic [13:0] h;
  } held_rect_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [13:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = 1'b0;
  logic [1:0]  in_storage_class = '0;
  logic [2:0]  in_page_index = '0;
  logic [12:0] in_pos_x = '0;
  logic [12:0] in_pos_y = '0;
  logic [13:0] in_size_w = 14'd1;
  logic [13:0] in_size_h = 14'd1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [2:0]  out_page;
  logic [12:0] out_x;
  logic [12:0] out_y;
  logic [13:0] out_extent;
  logic        out_page_dropped;
  int          fail_count;
  int          pending;
  bit          hold_sink = 1'b0;
  bit          sink_done = 1'b0;
  held_rect_t  held[$];
  logic [27:0] size_q[$];

  always #6 clk = ~clk;

  atlas_guillotine_allocator_unit DUT (.*);

  atlas_guillotine_allocator_checker u_checker (.*);

  // remember granted rectangles so that most releases are genuine
  always @(posedge clk) begin
    logic [27:0] sz;
    if (!rst_n) begin
      size_q.delete();
    end else begin
      if (in_valid && !in_stall) size_q.insert(size_q.size(), {in_size_w, in_size_h});
      if (out_valid && !out_stall && size_q.size() != 0) begin
        sz = size_q.pop_front();
        if (out_status == ST_OK && out_extent != 0)
          held.insert(held.size(), '{out_page, out_x, out_y, sz[27:14] + 14'd2,
                                     sz[13:0] + 14'd2});
      end
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // receiver side
  initial begin
    int n;
    @(posedge clk iff rst_n);
    while (!sink_done) begin
      if (hold_sink) begin
        out_stall <= 1'b1;
        for (int i = 0; i < 600; i++) @(posedge clk);
        out_stall <= 1'b0;
        wait (!hold_sink);
      end
      n = gap_len();
      out_stall <= (n != 0);
      for (int i = 0; i < n; i++) @(posedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
    end
    out_stall <= 1'b0;
  end

  task automatic send_word(logic m, logic [1:0] c, logic [2:0] pg, logic [12:0] x,
                           logic [12:0] y, logic [13:0] w, logic [13:0] h);
    in_valid <= 1'b1;
    in_mode <= m; in_storage_class <= c; in_page_index <= pg;
    in_pos_x <= x; in_pos_y <= y; in_size_w <= w; in_size_h <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    for (int i = gap_len(); i > 0; i--) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic alloc_word(logic [1:0] c, logic [13:0] w, logic [13:0] h);
    send_word(MODE_ALLOC, c, 3'($urandom), 13'($urandom), 13'($urandom), w, h);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_min_side(logic [13:0] v);
    drain();
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word();
    held_rect_t r;
    int k, pick;
    logic [13:0] w, h;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      k = $urandom_range(0, 9);
      w = (k < 7) ? 14'($urandom_range(1, 200))
                  : (k < 9 ? 14'($urandom_range(1, 8190)) : 14'($urandom));
      h = (k < 7) ? 14'($urandom_range(1, 200))
                  : (k < 9 ? 14'($urandom_range(1, 8190)) : 14'($urandom));
      alloc_word(2'($urandom_range(0, 3)), w, h);
    end else if (pick < 88 && held.size() != 0) begin
      k = $urandom_range(0, held.size() - 1);
      r = held[k];
      held.delete(k);
      send_word(MODE_RELEASE, 2'($urandom), r.page, r.x, r.y, r.w, r.h);
    end else begin
      send_word(1'($urandom), 2'($urandom), 3'($urandom), 13'($urandom), 13'($urandom),
                14'($urandom), 14'($urandom));
    end
  endtask

  initial begin
    held_rect_t r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: field extremes, bad sizes, both modes
    alloc_word(2'd0, 14'd1, 14'd1);
    alloc_word(2'd0, 14'd8190, 14'd8190);
    alloc_word(2'd1, 14'd0, 14'd5);
    alloc_word(2'd1, 14'd5, 14'd0);
    alloc_word(2'd2, 14'd8191, 14'd3);
    alloc_word(2'd2, 14'd16383, 14'd16383);
    alloc_word(2'd3, 14'd1022, 14'd1022);
    alloc_word(2'd3, 14'd1023, 14'd10);
    alloc_word(2'd0, 14'd30, 14'd40);
    for (int p = 0; p < 8; p++) alloc_word(2'(p), 14'd3000, 14'd3000);
    send_word(MODE_RELEASE, 2'd0, 3'd7, 13'h1FFF, 13'h1FFF, 14'h3FFF, 14'h3FFF);
    send_word(MODE_RELEASE, 2'd0, 3'd0, 13'd0, 13'd0, 14'd3, 14'd3);
    send_word(MODE_RELEASE, 2'd0, 3'd0, 13'd0, 13'd0, 14'd3, 14'd3);
    send_word(MODE_RELEASE, 2'd0, 3'd0, 13'd0, 13'd0, 14'd3, 14'd3);
    held.delete();
    set_min_side(14'd1);
    for (int i = 0; i < 40; i++) alloc_word(2'd0, 14'd1, 14'($urandom_range(1, 3)));
    set_min_side(14'd8192);
    alloc_word(2'd1, 14'd5, 14'd5);
    // receiver holds off while the sender keeps offering
    fork
      begin
        hold_sink = 1'b1;
        repeat (700) @(posedge clk);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 10; i++) random_word();
    join
    drain();
    rst_n <= 1'b1;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_min_side(14'd64);
        1: set_min_side(14'd1);
        2: set_min_side(14'd16);
        3: set_min_side(14'd8192);
        default: set_min_side(14'd256);
      endcase
      for (int i = 0; i < 250; i++) random_word();
      drain();
      // empty the atlas between phases via genuine releases
      while (held.size() != 0) begin
        r = held.pop_front();
        send_word(MODE_RELEASE, 2'd0, r.page, r.x, r.y, r.w, r.h);
      end
    end
    drain();
    sink_done = 1'b1;
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/aga_pkg.sv
hw/rtl/aga_ctrl.sv
hw/rtl/aga_dp.sv
hw/rtl/atlas_guillotine_allocator_unit.sv
tb/atlas_guillotine_allocator_checker.sv
tb/atlas_guillotine_allocator_unit_tb.sv
